// ----- sv/ast_pkg.sv -----
// ----------------------------------------------------------------------------
// ast_pkg
// Shared types and constants for the address sharing tracker.
// ----------------------------------------------------------------------------
package ast_pkg;

    localparam int TABLE_DEPTH = 4096;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = IDX_W + 1;
    localparam int ADDR_W      = 48;
    localparam int TID_W       = 32;

    typedef enum logic [1:0] {
        STATUS_HIT    = 2'd0,
        STATUS_INSERT = 2'd1,
        STATUS_FULL   = 2'd2
    } t_status;

    typedef struct packed {
        logic [ADDR_W-1:0] access_address;
        logic [TID_W-1:0]  thread_id;
    } t_access;

    typedef struct packed {
        logic    is_shared;
        t_status lookup_status;
    } t_result;

    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic [TID_W-1:0]  owner;
        logic              shared;
    } t_entry;

endpackage

// ----- sv/address_sharing_tracker.sv -----
// ----------------------------------------------------------------------------
// address_sharing_tracker
// Tracks which addresses are touched by more than one thread.
// ----------------------------------------------------------------------------
// One beat in carries an address and a thread id; one beat out tells whether
// that address is now shared and whether the lookup hit, inserted a new entry
// or found the table full. The table lives in a single-port-read RAM of
// TABLE_DEPTH entries and is searched linearly from entry 0, one RAM read per
// cycle, so the time a beat takes grows with the number of entries searched
// and is longest once the table has filled. The block works on one beat at a
// time; input stall is high from acceptance until the result has been placed
// in the output register. That register holds a finished result while the
// next beat is accepted. The RAM needs no clearing after reset: only entries
// below the fill count are ever read.
// ----------------------------------------------------------------------------
module address_sharing_tracker (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  ast_pkg::t_access i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output ast_pkg::t_result o_out_data
);
    import ast_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_FIN  = 3'b100
    } t_state;

    // table RAM
    t_entry r_mem [TABLE_DEPTH];
    t_entry r_rd_data;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_used, n_used;
    logic [CNT_W-1:0]  r_rd_idx, n_rd_idx;   // next entry to read
    logic [IDX_W-1:0]  r_cmp_idx;            // entry whose data is in r_rd_data
    logic              r_cmp_vld, n_cmp_vld;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic [TID_W-1:0]  r_tid, n_tid;
    t_result           r_res, n_res;
    logic              r_out_vld, n_out_vld;
    t_result           r_out, n_out;

    logic              rd_en;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_idx;
    t_entry            wr_data;
    logic              hit;
    logic              can_load;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    // read-compare against the latched beat
    assign hit      = r_cmp_vld && (r_rd_data.address == r_addr);
    assign can_load = !r_out_vld || !i_out_stall;

    always_comb begin
        n_state   = r_state;
        n_used    = r_used;
        n_rd_idx  = r_rd_idx;
        n_cmp_vld = 1'b0;
        n_addr    = r_addr;
        n_tid     = r_tid;
        n_res     = r_res;
        n_out     = r_out;
        n_out_vld = r_out_vld && i_out_stall;
        rd_en     = 1'b0;
        wr_en     = 1'b0;
        wr_idx    = r_used[IDX_W-1:0];
        wr_data   = r_rd_data;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_addr   = i_in_data.access_address;
                    n_tid    = i_in_data.thread_id;
                    n_rd_idx = '0;
                    if (r_used == '0) begin
                        // empty table: insert straight away
                        wr_en           = 1'b1;
                        wr_idx          = '0;
                        wr_data.address = i_in_data.access_address;
                        wr_data.owner   = i_in_data.thread_id;
                        wr_data.shared  = 1'b0;
                        n_used          = r_used + 1'b1;
                        n_res.is_shared     = 1'b0;
                        n_res.lookup_status = STATUS_INSERT;
                        n_state         = S_FIN;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (hit) begin
                    wr_en   = 1'b1;
                    wr_idx  = r_cmp_idx;
                    wr_data = r_rd_data;
                    if (r_rd_data.owner == '0) begin
                        wr_data.owner = r_tid;
                    end else if (r_rd_data.owner != r_tid) begin
                        wr_data.shared = 1'b1;
                    end
                    n_res.is_shared     = wr_data.shared;
                    n_res.lookup_status = STATUS_HIT;
                    n_state             = S_FIN;
                end else if (r_rd_idx < r_used) begin
                    rd_en     = 1'b1;
                    n_rd_idx  = r_rd_idx + 1'b1;
                    n_cmp_vld = 1'b1;
                end else if (r_cmp_vld) begin
                    // last used entry compared, no match
                    n_res.is_shared = 1'b0;
                    if (r_used == CNT_W'(TABLE_DEPTH)) begin
                        n_res.lookup_status = STATUS_FULL;
                    end else begin
                        wr_en           = 1'b1;
                        wr_idx          = r_used[IDX_W-1:0];
                        wr_data.address = r_addr;
                        wr_data.owner   = r_tid;
                        wr_data.shared  = 1'b0;
                        n_used          = r_used + 1'b1;
                        n_res.lookup_status = STATUS_INSERT;
                    end
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (can_load) begin
                    n_out     = r_res;
                    n_out_vld = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // RAM: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_idx] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[r_rd_idx[IDX_W-1:0]];
            r_cmp_idx <= r_rd_idx[IDX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_used    <= '0;
            r_cmp_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_used    <= n_used;
            r_cmp_vld <= n_cmp_vld;
            r_out_vld <= n_out_vld;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        r_rd_idx <= n_rd_idx;
        r_addr   <= n_addr;
        r_tid    <= n_tid;
        r_res    <= n_res;
        r_out    <= n_out;
    end

endmodule
